// ===== rtl/zida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zida_pkg
// Shared types and constants for the zone intrusion dwell alarm.
// ----------------------------------------------------------------------------
package zida_pkg;

  // Hysteresis added on a rising alert, and band above trigger for fast decay
  localparam int HYST_MS   = 2000;
  // Q1.14 rotation: size is scaled by one in Q14 before comparing
  localparam int Q14_SHIFT = 14;
  localparam int SPEED_W   = 16;
  localparam int REG16_W   = 16;
  localparam int ROT_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE_MODE  = 3'd0,
    CFG_CORNER_A    = 3'd1,
    CFG_CORNER_B    = 3'd2,
    CFG_ROTATION    = 3'd3,
    CFG_SPEED_WIN   = 3'd4,
    CFG_OCC_MIN     = 3'd5,
    CFG_TRIGGER     = 3'd6,
    CFG_FRAME_INTVL = 3'd7
  } cfg_idx_t;

  localparam int SHAPE_BOX = 0;

  // Stage load enables, driven by the top level handshake
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  // Zone test result for one item, third stage
  typedef struct packed {
    logic hit;
    logic fe;
  } hit_t;

endpackage

// ===== rtl/zida_zone.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zida_zone
// Three-stage zone and speed test: input register, products, compare.
// ----------------------------------------------------------------------------
module zida_zone #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  zida_pkg::pipe_ctl_t           ctl,
  input  logic signed [COORD_BITS-1:0]  x_cm,
  input  logic signed [COORD_BITS-1:0]  y_cm,
  input  logic signed [COORD_BITS-1:0]  z_cm,
  input  logic signed [zida_pkg::SPEED_W-1:0] speed_cms,
  input  logic                          point_valid,
  input  logic                          frame_end,
  input  logic                          shape_mode,
  input  logic [3*COORD_BITS-1:0]       corner_a,
  input  logic [3*COORD_BITS-1:0]       corner_b,
  input  logic [zida_pkg::ROT_W-1:0]    rotation,
  input  logic [zida_pkg::ROT_W-1:0]    speed_window,
  output zida_pkg::hit_t                hit_o
);

  localparam int C  = COORD_BITS;
  localparam int PW = C + 17;   // offset times Q1.14
  localparam int W  = C + 20;   // rotated compare width
  localparam int SW = zida_pkg::SPEED_W;

  // stage 1: input register
  logic signed [C-1:0]  p1_x, p1_y, p1_z;
  logic signed [SW-1:0] p1_speed;
  logic                 p1_pv, p1_fe;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      p1_x     <= x_cm;
      p1_y     <= y_cm;
      p1_z     <= z_cm;
      p1_speed <= speed_cms;
      p1_pv    <= point_valid;
      p1_fe    <= frame_end;
    end
  end

  logic signed [C-1:0]  ax, ay, az, bx, by, bz;
  logic signed [SW-1:0] cos_q, sin_q;
  logic [SW-1:0]        vmin, vmax;

  assign ax    = $signed(corner_a[C-1:0]);
  assign ay    = $signed(corner_a[2*C-1:C]);
  assign az    = $signed(corner_a[3*C-1:2*C]);
  assign bx    = $signed(corner_b[C-1:0]);
  assign by    = $signed(corner_b[2*C-1:C]);
  assign bz    = $signed(corner_b[3*C-1:2*C]);
  assign cos_q = $signed(rotation[SW-1:0]);
  assign sin_q = $signed(rotation[2*SW-1:SW]);
  assign vmin  = speed_window[SW-1:0];
  assign vmax  = speed_window[2*SW-1:SW];

  logic signed [C:0]    dx, dy, dz;
  logic signed [PW-1:0] dxc, dys, dyc, dxs;
  logic signed [C+2:0]  dz_e, dz_abs2, sz_e;
  logic signed [SW:0]   spd_e;
  logic [SW:0]          spd_abs;
  logic                 box_ok, dz_ok, spd_ok;

  always_comb begin
    dx  = (C+1)'(p1_x) - (C+1)'(ax);
    dy  = (C+1)'(p1_y) - (C+1)'(ay);
    dz  = (C+1)'(p1_z) - (C+1)'(az);
    dxc = dx * cos_q;
    dys = dy * sin_q;
    dyc = dy * cos_q;
    dxs = dx * sin_q;

    dz_e    = (C+3)'(dz);
    dz_abs2 = ((dz_e < 0) ? -dz_e : dz_e) <<< 1;
    sz_e    = (C+3)'(bz);
    dz_ok   = dz_abs2 <= sz_e;

    box_ok = (p1_x >= ax) && (p1_x <= bx) &&
             (p1_y >= ay) && (p1_y <= by) &&
             (p1_z >= az) && (p1_z <= bz);

    // |speed| of -32768 is 32768, kept in 17 bits
    spd_e   = (SW+1)'(p1_speed);
    spd_abs = (spd_e < 0) ? $unsigned(-spd_e) : $unsigned(spd_e);
    spd_ok  = (spd_abs > {1'b0, vmin}) && (spd_abs < {1'b0, vmax});
  end

  // stage 2: products and axis results
  logic signed [PW-1:0] p2_dxc, p2_dys, p2_dyc, p2_dxs;
  logic                 p2_dz_ok, p2_box_ok, p2_spd_ok, p2_pv, p2_fe;

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      p2_dxc    <= dxc;
      p2_dys    <= dys;
      p2_dyc    <= dyc;
      p2_dxs    <= dxs;
      p2_dz_ok  <= dz_ok;
      p2_box_ok <= box_ok;
      p2_spd_ok <= spd_ok;
      p2_pv     <= p1_pv;
      p2_fe     <= p1_fe;
    end
  end

  logic signed [W-1:0] rx, ry, rx_abs2, ry_abs2, sx_q, sy_q;
  logic                rot_ok, in_zone, hit;

  always_comb begin
    rx      = W'(p2_dxc) + W'(p2_dys);
    ry      = W'(p2_dyc) - W'(p2_dxs);
    rx_abs2 = ((rx < 0) ? -rx : rx) <<< 1;
    ry_abs2 = ((ry < 0) ? -ry : ry) <<< 1;
    sx_q    = W'(bx) <<< zida_pkg::Q14_SHIFT;
    sy_q    = W'(by) <<< zida_pkg::Q14_SHIFT;
    rot_ok  = (rx_abs2 <= sx_q) && (ry_abs2 <= sy_q) && p2_dz_ok;
    in_zone = (shape_mode == 1'(zida_pkg::SHAPE_BOX)) ? p2_box_ok : rot_ok;
    hit     = p2_pv && p2_spd_ok && in_zone;
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      hit_o.hit <= hit;
      hit_o.fe  <= p2_fe;
    end
  end

endmodule

// ===== rtl/zida_dwell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zida_dwell
// Frame hit counter, dwell time update, alert flag and result register.
// ----------------------------------------------------------------------------
module zida_dwell #(
  parameter int DWELL_BITS = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  zida_pkg::hit_t                s3,
  input  logic                          fire,
  input  logic                          out_ready,
  input  logic [zida_pkg::REG16_W-1:0]  occ_min,
  input  logic [zida_pkg::REG16_W-1:0]  trigger_ms,
  input  logic [zida_pkg::REG16_W-1:0]  frame_interval_ms,
  output logic                          out_valid,
  output logic                          alert,
  output logic                          alert_changed,
  output logic [COUNT_BITS-1:0]         hit_count,
  output logic [DWELL_BITS-1:0]         dwell_ms
);

  localparam int CW = COUNT_BITS;
  localparam int DW = DWELL_BITS;
  localparam int KW = (CW > zida_pkg::REG16_W) ? CW : zida_pkg::REG16_W;
  localparam int EW = DW + 2;
  localparam int NW = DW + 3;        // width of 7 * excess
  localparam int SH = NW + 4;        // reciprocal shift for divide by ten
  localparam int RW = NW + 1;
  localparam logic [RW-1:0] RECIP = RW'(((64'd1 << SH) + 64'd9) / 64'd10);
  localparam logic [EW-1:0] DMAX  = {2'b00, {DW{1'b1}}};
  localparam logic [EW-1:0] HYST  = EW'(zida_pkg::HYST_MS);

  logic [CW-1:0] hit_counter;
  logic [DW-1:0] dwell;
  logic          alert_flag;

  logic [CW-1:0]    cnt_eff;
  logic             occupied;
  logic [EW-1:0]    dw_e, delta_e, trig_h, sum, decay, dw1, dw2, dw_h;
  logic [DW-1:0]    excess, decay7;
  logic [NW-1:0]    e7;
  logic [NW+RW-1:0] prod;
  logic             now, rise;

  always_comb begin
    cnt_eff  = (s3.hit && hit_counter != {CW{1'b1}}) ? hit_counter + CW'(1) : hit_counter;
    occupied = KW'(cnt_eff) >= KW'(occ_min);

    dw_e    = EW'(dwell);
    delta_e = EW'(frame_interval_ms);
    trig_h  = EW'(trigger_ms) + HYST;
    sum     = dw_e + delta_e;

    // fast decay: floor(7 * excess / 10), divide by reciprocal multiply
    excess = DW'(dw_e - trig_h);
    e7     = (NW'(excess) << 3) - NW'(excess);
    prod   = (NW+RW)'(e7) * (NW+RW)'(RECIP);
    decay7 = prod[SH+DW-1:SH];
    decay  = (EW'(decay7) < delta_e) ? delta_e : EW'(decay7);

    if (occupied) begin
      dw1 = (sum > DMAX) ? DMAX : sum;
    end else if (dw_e > trig_h) begin
      dw1 = (dw_e > decay) ? dw_e - decay : '0;
    end else begin
      dw1 = (dw_e > delta_e) ? dw_e - delta_e : '0;
    end

    now  = dw1 >= EW'(trigger_ms);
    rise = now && !alert_flag;
    dw_h = dw1 + HYST;
    dw2  = rise ? ((dw_h > DMAX) ? DMAX : dw_h) : dw1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= '0;
      dwell       <= '0;
      alert_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        hit_counter <= s3.fe ? '0 : cnt_eff;
        if (s3.fe) begin
          dwell      <= DW'(dw2);
          alert_flag <= now;
        end
      end
      if (fire && s3.fe) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s3.fe) begin
      alert         <= now;
      alert_changed <= now != alert_flag;
      hit_count     <= cnt_eff;
      dwell_ms      <= DW'(dw2);
    end
  end

endmodule

// ===== rtl/zone_intrusion_dwell_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_intrusion_dwell_alarm
// Counts in-zone points in a speed window per frame; updates dwell and alert.
// ----------------------------------------------------------------------------
// Path: a frame-end item passes the stage registers, then the result register.
// Throughput: one item per cycle; the input stalls only when a frame result
// sits in the third stage while the output register is full and not taken.
// Reset: synchronous; empties the pipeline, clears count, dwell and alert,
// and loads the register defaults.
module zone_intrusion_dwell_alarm #(
  parameter int COORD_BITS = 16,
  parameter int DWELL_BITS = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        x_cm,
  input  logic signed [COORD_BITS-1:0]        y_cm,
  input  logic signed [COORD_BITS-1:0]        z_cm,
  input  logic signed [zida_pkg::SPEED_W-1:0] speed_cms,
  input  logic                                point_valid,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                alert,
  output logic                                alert_changed,
  output logic [COUNT_BITS-1:0]               hit_count,
  output logic [DWELL_BITS-1:0]               dwell_ms,
  input  logic                                cfg_we,
  input  logic [zida_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [3*COORD_BITS-1:0]             cfg_data
);

  localparam int CFG_W = 3 * COORD_BITS;
  localparam int R16   = zida_pkg::REG16_W;
  localparam int RTW   = zida_pkg::ROT_W;

  // configuration registers
  logic             shape_mode;
  logic [CFG_W-1:0] corner_a, corner_b;
  logic [RTW-1:0]   rotation, speed_window;
  logic [R16-1:0]   occ_min, trigger_ms, frame_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode        <= 1'b0;
      corner_a          <= '0;
      corner_b          <= '0;
      rotation          <= RTW'(16384);
      speed_window      <= '0;
      occ_min           <= R16'(1);
      trigger_ms        <= R16'(1000);
      frame_interval_ms <= R16'(100);
    end else if (cfg_we) begin
      unique case (zida_pkg::cfg_idx_t'(cfg_index))
        zida_pkg::CFG_SHAPE_MODE:  shape_mode        <= cfg_data[0];
        zida_pkg::CFG_CORNER_A:    corner_a          <= cfg_data;
        zida_pkg::CFG_CORNER_B:    corner_b          <= cfg_data;
        zida_pkg::CFG_ROTATION:    rotation          <= cfg_data[RTW-1:0];
        zida_pkg::CFG_SPEED_WIN:   speed_window      <= cfg_data[RTW-1:0];
        zida_pkg::CFG_OCC_MIN:     occ_min           <= cfg_data[R16-1:0];
        zida_pkg::CFG_TRIGGER:     trigger_ms        <= cfg_data[R16-1:0];
        zida_pkg::CFG_FRAME_INTVL: frame_interval_ms <= cfg_data[R16-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy; only a frame-end item in stage 3 can block
  logic s1_valid, s2_valid, s3_valid;
  logic stall3, s2_stall, s1_stall, fire3;
  zida_pkg::pipe_ctl_t ctl;
  zida_pkg::hit_t      s3;

  assign stall3   = s3_valid && s3.fe && out_valid && !out_ready;
  assign s2_stall = s2_valid && stall3;
  assign s1_stall = s1_valid && s2_stall;
  assign in_ready = !s1_stall;
  assign fire3    = s3_valid && !stall3;
  assign ctl.en1  = in_ready;
  assign ctl.en2  = !s2_stall;
  assign ctl.en3  = !stall3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ctl.en1) s1_valid <= in_valid;
      if (ctl.en2) s2_valid <= s1_valid;
      if (ctl.en3) s3_valid <= s2_valid;
    end
  end

  zida_zone #(
    .COORD_BITS(COORD_BITS)
  ) u_zone (
    .clk         (clk),
    .ctl         (ctl),
    .x_cm        (x_cm),
    .y_cm        (y_cm),
    .z_cm        (z_cm),
    .speed_cms   (speed_cms),
    .point_valid (point_valid),
    .frame_end   (frame_end),
    .shape_mode  (shape_mode),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .rotation    (rotation),
    .speed_window(speed_window),
    .hit_o       (s3)
  );

  zida_dwell #(
    .DWELL_BITS(DWELL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dwell (
    .clk              (clk),
    .rst              (rst),
    .s3               (s3),
    .fire             (fire3),
    .out_ready        (out_ready),
    .occ_min          (occ_min),
    .trigger_ms       (trigger_ms),
    .frame_interval_ms(frame_interval_ms),
    .out_valid        (out_valid),
    .alert            (alert),
    .alert_changed    (alert_changed),
    .hit_count        (hit_count),
    .dwell_ms         (dwell_ms)
  );

endmodule

// ===== rtl/zida_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zida_checker
// Port-level checks on result stream, alert edges and input readiness.
// ----------------------------------------------------------------------------
module zida_checker #(
  parameter int DWELL_BITS = 20
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  alert,
  input logic                  alert_changed,
  input logic [DWELL_BITS-1:0] dwell_ms
);

  // alert of the last delivered item
  logic prev_alert;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_alert <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_alert <= alert;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alert) && $stable(dwell_ms))
    else $error("result changed while stalled");

  a_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alert_changed == (alert != prev_alert))
    else $error("alert_changed does not match alert sequence");

  a_rise_hyst: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert && alert_changed |-> dwell_ms >= DWELL_BITS'(2000))
    else $error("rising alert without hysteresis");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind zone_intrusion_dwell_alarm zida_checker #(
  .DWELL_BITS(DWELL_BITS)
) u_zida_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .alert        (alert),
  .alert_changed(alert_changed),
  .dwell_ms     (dwell_ms)
);

// ===== bench/tb_zone_intrusion_dwell_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zone_intrusion_dwell_alarm
// Self-checking bench for the zone dwell alarm. A directed table covers reset
// defaults, window and box edges, rotated and empty zones, fast and linear
// decay, zero interval and alert edges. Random phases with fresh zone
// settings follow.
// Every frame result is checked against its table value (typed rows) or an in-bench dwell/alert predictor.
// ----------------------------------------------------------------------------
module tb_zone_intrusion_dwell_alarm;

  localparam int CLK_HALF    = 2;
  localparam int SETTLE      = 8;
  localparam int LIMIT       = 400000;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 50;
  localparam longint DWELL_MAX = (64'd1 << 20) - 1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] spd;
    logic               pv;
    logic               fe;
  } point_t;

  typedef struct packed {
    logic        alert;
    logic        chg;
    logic [15:0] cnt;
    logic [19:0] dwell;
  } frame_res_t;

  typedef struct packed {
    logic                 is_cfg;
    zida_pkg::cfg_idx_t   idx;
    logic [47:0]          data;
    point_t               pt;
    logic                 typed;
    frame_res_t           want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [15:0] x_cm = '0;
  logic signed [15:0] y_cm = '0;
  logic signed [15:0] z_cm = '0;
  logic signed [15:0] speed_cms = '0;
  logic        point_valid = 1'b0;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        alert;
  logic        alert_changed;
  logic [15:0] hit_count;
  logic [19:0] dwell_ms;
  logic        cfg_we = 1'b0;
  logic [zida_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // zone settings as the block should hold them
  logic        shape_q = 1'b0;
  logic [47:0] ca = '0;
  logic [47:0] cb = '0;
  logic [31:0] rot = 32'd16384;
  logic [31:0] spd_win = '0;
  logic [15:0] min_pts = 16'd1;
  logic [15:0] trig = 16'd1000;
  logic [15:0] intvl = 16'd100;

  // per-frame state
  logic [15:0] hits_q = '0;
  logic [19:0] dwell_q = '0;
  logic        alert_q = 1'b0;

  frame_res_t  frames_q[$];
  stim_row_t   dir_tab[$];
  int          errors = 0;
  int          frames_seen = 0;
  int          pts_sent = 0;
  int          settings_used = 0;
  int          cycle_cnt = 0;
  int          send_pct = 0;
  int          recv_pct = 0;

  zone_intrusion_dwell_alarm u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_cm         (x_cm),
    .y_cm         (y_cm),
    .z_cm         (z_cm),
    .speed_cms    (speed_cms),
    .point_valid  (point_valid),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .alert        (alert),
    .alert_changed(alert_changed),
    .hit_count    (hit_count),
    .dwell_ms     (dwell_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint fld(logic [47:0] r, int k);
    return longint'($signed(r[k*16 +: 16]));
  endfunction

  function automatic bit zone_hit(point_t p);
    longint px, py, pz, dx, dy, dz, c, s, rx, ry;
    px = p.x;
    py = p.y;
    pz = p.z;
    if (!shape_q)
      return px >= fld(ca, 0) && px <= fld(cb, 0) &&
             py >= fld(ca, 1) && py <= fld(cb, 1) &&
             pz >= fld(ca, 2) && pz <= fld(cb, 2);
    dx = px - fld(ca, 0);
    dy = py - fld(ca, 1);
    dz = pz - fld(ca, 2);
    c  = longint'($signed(rot[15:0]));
    s  = longint'($signed(rot[31:16]));
    rx = dx * c + dy * s;
    ry = dy * c - dx * s;
    if (rx < 0) rx = -rx;
    if (ry < 0) ry = -ry;
    if (dz < 0) dz = -dz;
    // exact Q14 compare, no rounding
    return 2 * rx <= fld(cb, 0) * (longint'(1) << zida_pkg::Q14_SHIFT) &&
           2 * ry <= fld(cb, 1) * (longint'(1) << zida_pkg::Q14_SHIFT) &&
           2 * dz <= fld(cb, 2);
  endfunction

  // Counts the point, and on a frame end updates dwell/alert and yields a result
  function automatic bit frame_step(point_t p, output frame_res_t r);
    longint spd, vmin, vmax, dw, decay, tr, iv;
    bit now, flip;
    r = '0;
    flip = 1'b0;
    spd = p.spd;
    if (spd < 0) spd = -spd;
    vmin = spd_win[15:0];
    vmax = spd_win[31:16];
    if (p.pv && spd > vmin && spd < vmax && zone_hit(p))
      if (hits_q != 16'hFFFF) hits_q++;
    if (!p.fe)
      return 1'b0;
    dw = dwell_q;
    tr = trig;
    iv = intvl;
    if (hits_q >= min_pts) begin
      dw += iv;
      if (dw > DWELL_MAX) dw = DWELL_MAX;
    end else if (dw > tr + zida_pkg::HYST_MS) begin
      decay = ((dw - tr - zida_pkg::HYST_MS) * 7) / 10;
      if (decay < iv) decay = iv;
      dw = (dw > decay) ? dw - decay : 0;
    end else begin
      dw = (dw > iv) ? dw - iv : 0;
    end
    now = (dw >= tr);
    if (now != alert_q) begin
      if (now) begin
        dw += zida_pkg::HYST_MS;
        if (dw > DWELL_MAX) dw = DWELL_MAX;
      end
      alert_q = now;
      flip = 1'b1;
    end
    dwell_q = dw[19:0];
    r.alert = alert_q;
    r.chg   = flip;
    r.cnt   = hits_q;
    r.dwell = dwell_q;
    hits_q  = '0;
    return 1'b1;
  endfunction

  // Leaves cfg_we high; the caller lowers it after the last write of a group
  task automatic write_reg(zida_pkg::cfg_idx_t idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      zida_pkg::CFG_SHAPE_MODE:  shape_q = val[0];
      zida_pkg::CFG_CORNER_A:    ca      = val;
      zida_pkg::CFG_CORNER_B:    cb      = val;
      zida_pkg::CFG_ROTATION:    rot     = val[31:0];
      zida_pkg::CFG_SPEED_WIN:   spd_win = val[31:0];
      zida_pkg::CFG_OCC_MIN:     min_pts = val[15:0];
      zida_pkg::CFG_TRIGGER:     trig    = val[15:0];
      zida_pkg::CFG_FRAME_INTVL: intvl   = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Block idle: all results back, then a settle wait for items still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_point(point_t p, bit typed, frame_res_t want_in);
    frame_res_t r;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    x_cm        <= p.x;
    y_cm        <= p.y;
    z_cm        <= p.z;
    speed_cms   <= p.spd;
    point_valid <= p.pv;
    frame_end   <= p.fe;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (frame_step(p, r))
      frames_q.insert(frames_q.size(), typed ? want_in : r);
    pts_sent++;
  endtask

  task automatic row_cfg(zida_pkg::cfg_idx_t idx, logic [47:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic row_pt(int x, int y, int z, int s, bit pv, bit fe,
                        bit typed, bit a, bit c, int cnt, int dw);
    stim_row_t row;
    row = '0;
    row.pt.x = x[15:0];
    row.pt.y = y[15:0];
    row.pt.z = z[15:0];
    row.pt.spd = s[15:0];
    row.pt.pv = pv;
    row.pt.fe = fe;
    row.typed = typed;
    row.want.alert = a;
    row.want.chg = c;
    row.want.cnt = cnt[15:0];
    row.want.dwell = dw[19:0];
    dir_tab.insert(dir_tab.size(), row);
  endtask

  function automatic point_t random_point(int fe_div);
    point_t p;
    int k, a, b, lo, hi, half, v, vmin, vmax, mag;
    logic [15:0] c[3];
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(99) < 65) begin
        a = int'(fld(ca, k));
        b = int'(fld(cb, k));
        if (!shape_q) begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end else begin
          if (k == 2) half = ((b < 0) ? -b : b) / 2 + 2;
          else half = int'((((fld(cb, 0) < 0) ? -fld(cb, 0) : fld(cb, 0)) +
                            ((fld(cb, 1) < 0) ? -fld(cb, 1) : fld(cb, 1))) / 2 + 4);
          lo = a - half;
          hi = a + half;
        end
        v = lo - 3 + int'($urandom_range(hi - lo + 6));
        c[k] = v[15:0];
      end else begin
        c[k] = 16'($urandom);
      end
    end
    p.x = c[0];
    p.y = c[1];
    p.z = c[2];
    vmin = spd_win[15:0];
    vmax = spd_win[31:16];
    if ($urandom_range(9) < 7 && vmin < vmax) begin
      hi = (vmax > 32768) ? 32768 : vmax;
      lo = (vmin > hi) ? hi : vmin;
      mag = lo + int'($urandom_range(hi - lo));
    end else begin
      mag = $urandom_range(65535);
    end
    p.spd = $urandom_range(1) ? -mag[15:0] : mag[15:0];
    p.pv = ($urandom_range(9) != 0);
    p.fe = ($urandom_range(fe_div - 1) == 0);
    return p;
  endfunction

  task automatic setup_phase(int ph);
    int k, r, lo, hi, cen, half, vmin, vmax;
    logic [47:0] a_reg, b_reg;
    logic [31:0] rot_v;
    logic        shp;
    logic [15:0] mp, tg, iv;
    shp = 1'($urandom_range(1));
    for (k = 0; k < 3; k++) begin
      r = $urandom_range(7);
      cen = $urandom_range(4000);
      cen -= 2000;
      half = $urandom_range(300);
      if (!shp) begin
        if (r == 0) begin
          lo = -32768;
          hi = 32767;
        end else if (r == 1) begin
          // minimum above maximum: empty box
          lo = cen + half + 1;
          hi = cen - half;
        end else begin
          lo = cen - half;
          hi = cen + half;
        end
      end else begin
        lo = (r == 0) ? int'($urandom) : cen;
        if (r == 1) hi = -int'($urandom_range(1, 50));
        else if (r == 2) hi = 32767;
        else hi = $urandom_range(600);
      end
      a_reg[k*16 +: 16] = lo[15:0];
      b_reg[k*16 +: 16] = hi[15:0];
    end
    case ($urandom_range(7))
      0: rot_v = 32'h0000_4000;
      1: rot_v = 32'h4000_0000;
      2: rot_v = 32'h2D41_2D41;
      3: rot_v = 32'h0000_C000;
      4: rot_v = 32'h2000_376D;
      5: rot_v = 32'hD2BF_2D41;
      6: rot_v = 32'h8000_8000;
      default: rot_v = $urandom;
    endcase
    r = $urandom_range(7);
    if (r == 0) begin
      vmin = 0;
      vmax = 65535;
    end else if (r == 1) begin
      vmin = $urandom_range(65535);
      vmax = $urandom_range(vmin);
    end else begin
      vmin = $urandom_range(300);
      vmax = $urandom_range(400, 32767);
    end
    r = $urandom_range(7);
    mp = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 4));
    r = $urandom_range(7);
    tg = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(3000));
    r = $urandom_range(7);
    iv = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 400));
    // phase 1 pushes dwell into saturation, phase 2 decays it back down
    if (ph == 1) begin
      mp = 16'd0;
      iv = 16'hFFFF;
    end else if (ph == 2) begin
      mp = 16'hFFFF;
      tg = 16'd500;
    end
    write_reg(zida_pkg::CFG_SHAPE_MODE, {47'd0, shp});
    write_reg(zida_pkg::CFG_CORNER_A, a_reg);
    write_reg(zida_pkg::CFG_CORNER_B, b_reg);
    write_reg(zida_pkg::CFG_ROTATION, {16'd0, rot_v});
    write_reg(zida_pkg::CFG_SPEED_WIN, {16'd0, vmax[15:0], vmin[15:0]});
    write_reg(zida_pkg::CFG_OCC_MIN, {32'd0, mp});
    write_reg(zida_pkg::CFG_TRIGGER, {32'd0, tg});
    write_reg(zida_pkg::CFG_FRAME_INTVL, {32'd0, iv});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin : check_results
    frame_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (frames_q.size() == 0) begin
        report_mismatch($sformatf("result with no frame pending: alert=%0d chg=%0d cnt=%0d dwell=%0d",
                                  alert, alert_changed, hit_count, dwell_ms));
      end else begin
        want = frames_q[0];
        frames_q.delete(0);
        frames_seen++;
        if (alert !== want.alert)
          report_mismatch($sformatf("frame %0d alert %0d, want %0d",
                                    frames_seen, alert, want.alert));
        if (alert_changed !== want.chg)
          report_mismatch($sformatf("frame %0d alert_changed %0d, want %0d",
                                    frames_seen, alert_changed, want.chg));
        if (hit_count !== want.cnt)
          report_mismatch($sformatf("frame %0d hit_count %0d, want %0d",
                                    frames_seen, hit_count, want.cnt));
        if (dwell_ms !== want.dwell)
          report_mismatch($sformatf("frame %0d dwell_ms %0d, want %0d",
                                    frames_seen, dwell_ms, want.dwell));
      end
    end
    out_ready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("zone_intrusion_dwell_alarm: mismatch");
    $finish;
  end

  initial begin : stimulus
    int i, ph, n, fe_div;
    point_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // defaults: empty speed window, nothing counts
    row_pt(32767, -32768, 32767, 32767, 1, 1, 1, 0, 0, 0, 0);
    row_pt(-32768, 32767, -32768, -32768, 1, 1, 1, 0, 0, 0, 0);
    row_pt(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
    // minimum count 0: every frame occupied
    row_cfg(zida_pkg::CFG_OCC_MIN, 48'd0);
    row_pt(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 100);
    // rising edge adds hysteresis
    row_cfg(zida_pkg::CFG_TRIGGER, 48'd150);
    row_pt(0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 2200);
    // box -100..100, speed window 10..1000
    row_cfg(zida_pkg::CFG_OCC_MIN, 48'd1);
    row_cfg(zida_pkg::CFG_CORNER_A, 48'hFF9C_FF9C_FF9C);
    row_cfg(zida_pkg::CFG_CORNER_B, 48'h0064_0064_0064);
    row_cfg(zida_pkg::CFG_SPEED_WIN, 48'h0000_03E8_000A);
    row_pt(0, 0, 0, 500, 1, 0, 0, 0, 0, 0, 0);
    row_pt(-100, 100, -100, -999, 1, 0, 0, 0, 0, 0, 0);
    row_pt(101, 0, 0, 500, 1, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, 10, 1, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, -1000, 1, 0, 0, 0, 0, 0, 0);
    row_pt(50, 50, 50, 500, 0, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, 20, 1, 1, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    row_cfg(zida_pkg::CFG_FRAME_INTVL, 48'd0);
    row_pt(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // rotated 45 deg, size 200 x 100 x 50 about the origin
    row_cfg(zida_pkg::CFG_SHAPE_MODE, 48'd1);
    row_cfg(zida_pkg::CFG_CORNER_A, 48'd0);
    row_cfg(zida_pkg::CFG_CORNER_B, 48'h0032_0064_00C8);
    row_cfg(zida_pkg::CFG_ROTATION, 48'h0000_2D41_2D41);
    row_cfg(zida_pkg::CFG_FRAME_INTVL, 48'd100);
    row_pt(70, 70, 0, 500, 1, 0, 0, 0, 0, 0, 0);
    row_pt(80, 80, 0, 500, 1, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 26, 500, 1, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 25, -500, 1, 1, 0, 0, 0, 0, 0);
    // negative x size: empty zone
    row_cfg(zida_pkg::CFG_CORNER_B, 48'h0032_0064_FFFF);
    row_pt(0, 0, 0, 500, 1, 1, 0, 0, 0, 0, 0);
    // top trigger drops the alert
    row_cfg(zida_pkg::CFG_TRIGGER, 48'hFFFF);
    row_pt(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // min == max speed: nothing qualifies
    row_cfg(zida_pkg::CFG_SPEED_WIN, 48'h0000_0064_0064);
    row_cfg(zida_pkg::CFG_CORNER_B, 48'h0032_0064_00C8);
    row_pt(0, 0, 0, 100, 1, 0, 0, 0, 0, 0, 0);
    row_pt(0, 0, 0, -32768, 1, 1, 0, 0, 0, 0, 0);

    for (i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i-1].is_cfg) wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
        if (i + 1 == dir_tab.size() || !dir_tab[i+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].want);
      end
    end
    settings_used += 7;

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 49; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 49; end
        default: begin send_pct = 36; recv_pct = 36; end
      endcase
      setup_phase(ph);
      fe_div = (ph == 1) ? 2 : int'($urandom_range(2, 8));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        p = random_point(fe_div);
        if (n == PHASE_ITEMS - 1) p.fe = 1'b1;
        send_point(p, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (frames_q.size() != 0)
      report_mismatch($sformatf("%0d frame results never arrived", frames_q.size()));
    $display("Drove %0d items (directed table, %0d random phases with idle and stall mixes),",
             pts_sent, PHASES);
    $display("checked %0d frame results across %0d register settings, %0d errors.",
             frames_seen, settings_used, errors);
    if (errors == 0)
      $display("zone_intrusion_dwell_alarm: match");
    else
      $display("zone_intrusion_dwell_alarm: mismatch");
    $finish;
  end

endmodule

// ===== zone_intrusion_dwell_alarm.f =====
rtl/zida_pkg.sv
rtl/zida_zone.sv
rtl/zida_dwell.sv
rtl/zone_intrusion_dwell_alarm.sv
rtl/zida_checker.sv
bench/tb_zone_intrusion_dwell_alarm.sv
